@@ design/rbf_pkg.sv @@
// shared types, constants and exponential table builders for the rbf kernel evaluator
package rbf_pkg;

  localparam int unsigned SumW   = 48;
  localparam int unsigned GammaW = 24;
  localparam int unsigned RomW   = 32;
  localparam int unsigned GtabN  = 257;
  localparam int unsigned EtabN  = 16;
  localparam logic [15:0] KernelOne = 16'd32768;

  typedef struct packed {
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic [15:0] kernel_value;
    logic        sum_saturated;
  } out_item_t;

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic            ovf;
  } acc_entry_t;

  // floor division by a small loop count, elaboration only
  function automatic logic [63:0] div_small(input logic [63:0] v, input logic [4:0] n);
    logic [63:0] q;
    case (n)
      5'd1:    q = v;
      5'd2:    q = v / 64'd2;
      5'd3:    q = v / 64'd3;
      5'd4:    q = v / 64'd4;
      5'd5:    q = v / 64'd5;
      5'd6:    q = v / 64'd6;
      5'd7:    q = v / 64'd7;
      5'd8:    q = v / 64'd8;
      5'd9:    q = v / 64'd9;
      5'd10:   q = v / 64'd10;
      5'd11:   q = v / 64'd11;
      5'd12:   q = v / 64'd12;
      5'd13:   q = v / 64'd13;
      5'd14:   q = v / 64'd14;
      5'd15:   q = v / 64'd15;
      5'd16:   q = v / 64'd16;
      5'd17:   q = v / 64'd17;
      5'd18:   q = v / 64'd18;
      5'd19:   q = v / 64'd19;
      5'd20:   q = v / 64'd20;
      5'd21:   q = v / 64'd21;
      5'd22:   q = v / 64'd22;
      5'd23:   q = v / 64'd23;
      5'd24:   q = v / 64'd24;
      5'd25:   q = v / 64'd25;
      5'd26:   q = v / 64'd26;
      5'd27:   q = v / 64'd27;
      5'd28:   q = v / 64'd28;
      5'd29:   q = v / 64'd29;
      5'd30:   q = v / 64'd30;
      5'd31:   q = v / 64'd31;
      default: q = v;
    endcase
    return q;
  endfunction

  // exp(-j/256) in q1.31 by alternating series in q.40
  function automatic logic [RomW-1:0] gtab_entry(input int unsigned j);
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] res;
    t    = 64'(j) * 64'd256;
    term = 64'd1 << 40;
    pos  = term;
    neg  = '0;
    for (int unsigned n = 1; n < 32; n++) begin
      if (term != '0) begin
        term = div_small((term * t) >> 16, 5'(n));
        if ((n & 1) != 0) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
    end
    res = (pos - neg + 64'd256) >> 9;
    return res[RomW-1:0];
  endfunction

  // exp(-k) in q1.31 by repeated rounded products
  function automatic logic [RomW-1:0] etab_entry(input int unsigned k);
    logic [63:0] e;
    logic [63:0] g;
    e = 64'd1 << 31;
    g = 64'(gtab_entry(256));
    for (int unsigned i = 0; i < k; i++) begin
      e = (e * g + (64'd1 << 30)) >> 31;
    end
    return e[RomW-1:0];
  endfunction

endpackage

@@ design/rbf_front.sv @@
// front part: squared difference per item and saturating distance accumulator
module rbf_front #(
  parameter int unsigned QUEUE_DEPTH = 4,
  localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rbf_pkg::in_item_t  in_data_i,
  input  logic [LW-1:0]      level_i,
  output logic               push_o,
  output rbf_pkg::acc_entry_t entry_o
);

  logic                      stg_valid_q;
  logic                      stg_last_q;
  logic [31:0]               sq_q;
  logic [rbf_pkg::SumW-1:0]  sum_q;
  logic                      ovf_q;

  logic signed [16:0]        diff;
  logic [16:0]               mag;
  logic [33:0]               sq_full;
  logic                      accept;
  logic                      pending;
  logic [rbf_pkg::SumW:0]    sum_ext;
  logic                      sat;
  logic [rbf_pkg::SumW-1:0]  new_sum;
  logic                      new_ovf;

  assign diff    = {in_data_i.first_value[15], in_data_i.first_value}
                 - {in_data_i.second_value[15], in_data_i.second_value};
  assign mag     = diff[16] ? 17'(-diff) : 17'(diff);
  assign sq_full = 34'(mag) * 34'(mag);
  assign accept  = in_valid_i && !in_stall_o;

  // a last item in the stage pushes this cycle and is not yet counted in level_i
  assign pending    = stg_valid_q && stg_last_q;
  assign in_stall_o = ({1'b0, level_i} + (LW + 1)'(pending)) >= (LW + 1)'(QUEUE_DEPTH);

  assign sum_ext = {1'b0, sum_q} + {17'd0, sq_q};
  assign sat     = sum_ext[rbf_pkg::SumW];
  assign new_sum = sat ? '1 : sum_ext[rbf_pkg::SumW-1:0];
  assign new_ovf = ovf_q | sat;

  assign push_o        = stg_valid_q && stg_last_q;
  assign entry_o.sum   = new_sum;
  assign entry_o.ovf   = new_ovf;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q       <= sq_full[31:0];
      stg_last_q <= in_data_i.last_element;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
    end else begin
      stg_valid_q <= accept;
      if (stg_valid_q) begin
        if (stg_last_q) begin
          sum_q <= '0;
          ovf_q <= 1'b0;
        end else begin
          sum_q <= new_sum;
          ovf_q <= new_ovf;
        end
      end
    end
  end

endmodule

@@ design/rbf_queue.sv @@
// short queue of finished distance sums between front and back
module rbf_queue #(
  parameter int unsigned QUEUE_DEPTH = 4,
  localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned PW = $clog2(QUEUE_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rbf_pkg::acc_entry_t entry_i,
  input  logic                pop_i,
  output rbf_pkg::acc_entry_t entry_o,
  output logic [LW-1:0]       level_o
);

  rbf_pkg::acc_entry_t mem_q [QUEUE_DEPTH];
  logic [PW-1:0]       wr_ptr_q;
  logic [PW-1:0]       rd_ptr_q;
  logic [LW-1:0]       level_q;
  logic [PW-1:0]       wr_ptr_d;
  logic [PW-1:0]       rd_ptr_d;
  logic [LW-1:0]       level_d;

  assign entry_o = mem_q[rd_ptr_q];
  assign level_o = level_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      level_d = level_q + LW'(1);
    end else if (pop_i && !push_i) begin
      level_d = level_q - LW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

endmodule

@@ design/rbf_back.sv @@
// back part: gamma scaling, table exponential with interpolation, output register
module rbf_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [rbf_pkg::GammaW-1:0]       gamma_i,
  input  logic                             avail_i,
  input  rbf_pkg::acc_entry_t              entry_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output rbf_pkg::out_item_t               out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_LOOK,
    ST_COMB,
    ST_EMUL,
    ST_FIN
  } state_e;

  logic [rbf_pkg::RomW-1:0] gtab_rom [rbf_pkg::GtabN];
  logic [rbf_pkg::RomW-1:0] etab_rom [rbf_pkg::EtabN];

  for (genvar g = 0; g < rbf_pkg::GtabN; g++) begin : g_gtab
    localparam logic [rbf_pkg::RomW-1:0] GVal = rbf_pkg::gtab_entry(g);
    assign gtab_rom[g] = GVal;
  end

  for (genvar e = 0; e < rbf_pkg::EtabN; e++) begin : g_etab
    localparam logic [rbf_pkg::RomW-1:0] EVal = rbf_pkg::etab_entry(e);
    assign etab_rom[e] = EVal;
  end

  state_e                   state_q;
  logic [rbf_pkg::SumW-1:0] sum_q;
  logic                     ovf_q;
  logic [47:0]              phi_q;
  logic [47:0]              plo_q;
  logic                     zero_q;
  logic [3:0]               k_q;
  logic [7:0]               j_q;
  logic [7:0]               r_q;
  logic [40:0]              pa_q;
  logic [40:0]              pb_q;
  logic [31:0]              frac_q;
  logic [63:0]              eprod_q;
  logic                     out_valid_q;
  rbf_pkg::out_item_t       out_data_q;

  logic [48:0]              x;
  logic [8:0]               j_next;
  logic [8:0]               r_inv;
  logic [41:0]              mix;
  logic [63:0]              rnd;
  logic [16:0]              res;
  logic [15:0]              kernel;
  logic                     out_free;

  assign x        = {1'b0, phi_q} + {25'd0, plo_q[47:24]};
  assign j_next   = {1'b0, j_q} + 9'd1;
  assign r_inv    = 9'd256 - {1'b0, r_q};
  assign mix      = {1'b0, pa_q} + {1'b0, pb_q} + 42'd128;
  assign rnd      = eprod_q + (64'd1 << 46);
  assign res      = rnd[63:47];
  assign kernel   = zero_q ? 16'd0
                  : (res > {1'b0, rbf_pkg::KernelOne}) ? rbf_pkg::KernelOne : res[15:0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && avail_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (avail_i) begin
            sum_q   <= entry_i.sum;
            ovf_q   <= entry_i.ovf;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          phi_q   <= 48'(gamma_i) * 48'(sum_q[47:24]);
          plo_q   <= 48'(gamma_i) * 48'(sum_q[23:0]);
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          zero_q  <= |x[48:20];
          k_q     <= x[19:16];
          j_q     <= x[15:8];
          r_q     <= x[7:0];
          state_q <= ST_LOOK;
        end
        ST_LOOK: begin
          pa_q    <= 41'(gtab_rom[{1'b0, j_q}]) * 41'(r_inv);
          pb_q    <= 41'(gtab_rom[j_next]) * 41'(r_q);
          state_q <= ST_COMB;
        end
        ST_COMB: begin
          frac_q  <= mix[39:8];
          state_q <= ST_EMUL;
        end
        ST_EMUL: begin
          eprod_q <= 64'(etab_rom[k_q]) * 64'(frac_q);
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q                <= 1'b1;
            out_data_q.kernel_value    <= kernel;
            out_data_q.sum_saturated   <= ovf_q;
            state_q                    <= ST_IDLE;
          end else if (out_valid_q && !out_stall_i) begin
            out_valid_q                <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/rbf_kernel_evaluator.sv @@
// top level of the gaussian rbf kernel evaluator
//
// input channel: one item per element pair (first_value, second_value in q4.12,
// last_element marks the final pair of a vector). items are taken on
// in_valid_i high and in_stall_o low, one per cycle while the queue has room.
// each item adds (first - second)^2 to a 48-bit sum that saturates and flags.
// output channel: one item per vector, on the item marked last, holding
// exp(-gamma * sum) in unsigned q1.15 and the saturation flag.
// the back part takes one vector at a time through its steps (two gamma
// multiplies, add, table interpolation, exp multiply, rounding) and pops no
// new vector until the last result has entered the output register; elements
// stream at one per cycle while the queue has room, the queue absorbing bursts.
// gamma is written through cfg_valid_i/cfg_data_i; the user must write it only while
// the block is idle, which the block itself does not enforce. cfg_ready_o is always high.
// reset clears the sum, the queue and the output valid flag and sets gamma to 1.0.
// a stalled output item holds in the output register while the front keeps
// taking items until the queue fills, then in_stall_o rises.
module rbf_kernel_evaluator #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  rbf_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rbf_pkg::out_item_t         out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [rbf_pkg::GammaW-1:0] cfg_data_i
);

  localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);

  logic [rbf_pkg::GammaW-1:0] gamma_q;
  logic                       push;
  logic                       pop;
  rbf_pkg::acc_entry_t        push_entry;
  rbf_pkg::acc_entry_t        head_entry;
  logic [LW-1:0]              level;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= rbf_pkg::GammaW'(65536);
    end else if (cfg_valid_i && cfg_ready_o) begin
      gamma_q <= cfg_data_i;
    end
  end

  rbf_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .level_i   (level),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  rbf_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .entry_o(head_entry),
    .level_o(level)
  );

  rbf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gamma_i    (gamma_q),
    .avail_i    (level != '0),
    .entry_i    (head_entry),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (level < LW'(QUEUE_DEPTH)))
    else $error("queue push while full");

  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (level != '0))
    else $error("queue pop while empty");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level == LW'(QUEUE_DEPTH)) |-> in_stall_o)
    else $error("input not stalled with full queue");

endmodule

@@ tb/rbf_checker.sv @@
// checker for the rbf kernel evaluator: predicts kernel values and compares output items
module rbf_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  rbf_pkg::in_item_t          in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  rbf_pkg::out_item_t         out_data_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [rbf_pkg::GammaW-1:0] cfg_data_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);

  localparam logic [rbf_pkg::GammaW-1:0] GammaOne = 24'h010000;
  localparam logic [63:0] SumMax = (64'd1 << rbf_pkg::SumW) - 64'd1;
  localparam logic [63:0] XLimit = 64'd16 << 16;

  logic [63:0]                int_rom [rbf_pkg::EtabN];
  logic [63:0]                frac_rom[rbf_pkg::GtabN];
  logic [rbf_pkg::GammaW-1:0] gamma_q;
  logic [rbf_pkg::SumW-1:0]   dist_sum;
  logic                       sat_seen;
  int unsigned                mismatches;
  rbf_pkg::out_item_t         kernel_q[$];

  function automatic logic [63:0] neg_exp_q40(input logic [63:0] t);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'd1 << 40;
    pos  = term;
    neg  = '0;
    for (int n = 1; n < 32 && term != 0; n++) begin
      term = (term * t) / (64'(n) * 64'd65536);
      if (n % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return pos - neg;
  endfunction

  initial begin
    for (int j = 0; j < rbf_pkg::GtabN; j++) begin
      frac_rom[j] = (neg_exp_q40(64'(j) * 64'd256) + 64'd256) >> 9;
    end
    int_rom[0] = 64'd1 << 31;
    for (int k = 1; k < rbf_pkg::EtabN; k++) begin
      int_rom[k] = (int_rom[k-1] * frac_rom[256] + (64'd1 << 30)) >> 31;
    end
  end

  function automatic logic [15:0] rbf_kernel(input logic [rbf_pkg::SumW-1:0] s,
                                             input logic [rbf_pkg::GammaW-1:0] g);
    logic [63:0] gw;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] x;
    logic [63:0] k;
    logic [63:0] j;
    logic [63:0] r;
    logic [63:0] frac;
    logic [63:0] res;
    gw = 64'(g);
    hi = 64'(s) >> 24;
    lo = 64'(s) & 64'hFF_FFFF;
    x  = gw * hi + ((gw * lo) >> 24);
    if (x >= XLimit) begin
      return 16'd0;
    end
    k    = x >> 16;
    j    = (x & 64'hFFFF) >> 8;
    r    = x & 64'hFF;
    frac = (frac_rom[j] * (64'd256 - r) + frac_rom[j+1] * r + 64'd128) >> 8;
    res  = (int_rom[k] * frac + (64'd1 << 46)) >> 47;
    if (res > 64'd32768) begin
      res = 64'd32768;
    end
    return res[15:0];
  endfunction

  function automatic void add_pair(input rbf_pkg::in_item_t it);
    int                 a;
    int                 b;
    int                 d;
    logic [63:0]        sq;
    rbf_pkg::out_item_t want;
    a = int'($signed(it.first_value));
    b = int'($signed(it.second_value));
    d = a - b;
    if (d < 0) begin
      d = -d;
    end
    sq = 64'(d) * 64'(d);
    if (sq > SumMax - 64'(dist_sum)) begin
      dist_sum = '1;
      sat_seen = 1'b1;
    end else begin
      dist_sum = dist_sum + sq[rbf_pkg::SumW-1:0];
    end
    if (it.last_element) begin
      want.kernel_value  = rbf_kernel(dist_sum, gamma_q);
      want.sum_saturated = sat_seen;
      kernel_q.push_back(want);
      dist_sum = '0;
      sat_seen = 1'b0;
    end
  endfunction

  function automatic void check_result(input rbf_pkg::out_item_t got);
    rbf_pkg::out_item_t want;
    if (kernel_q.size() == 0) begin
      $error("result item with no expected item pending");
      mismatches++;
    end else begin
      want = kernel_q.pop_front();
      if (got.kernel_value !== want.kernel_value) begin
        $error("kernel_value: expected %0d, actual %0d", want.kernel_value, got.kernel_value);
        mismatches++;
      end
      if (got.sum_saturated !== want.sum_saturated) begin
        $error("sum_saturated: expected %0d, actual %0d",
               want.sum_saturated, got.sum_saturated);
        mismatches++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q    = GammaOne;
      dist_sum   = '0;
      sat_seen   = 1'b0;
      mismatches = 0;
      kernel_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        gamma_q = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        add_pair(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_result(out_data_i);
      end
      fail_count_o <= mismatches;
      pending_o    <= kernel_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// testbench top for the rbf kernel evaluator: stimulus, flow control and verdict
module tb_top;

  localparam int unsigned DrainCycles = 16;
  localparam int unsigned PhaseItems  = 50;

  logic                       clk_i      = 1'b0;
  logic                       rst_ni     = 1'b0;
  logic                       in_valid   = 1'b0;
  logic                       in_stall;
  rbf_pkg::in_item_t          in_data    = '0;
  logic                       out_valid;
  logic                       out_stall  = 1'b0;
  rbf_pkg::out_item_t         out_data;
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready;
  logic [rbf_pkg::GammaW-1:0] cfg_data   = '0;
  int unsigned                fail_count;
  int unsigned                pending_count;
  int unsigned                send_idle_pct = 16;
  int unsigned                recv_idle_pct = 46;

  rbf_kernel_evaluator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  rbf_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_pair(input int a, input int b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{first_value: 16'(a), second_value: 16'(b), last_element: last};
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_gamma(input logic [rbf_pkg::GammaW-1:0] g);
    cfg_valid <= 1'b1;
    cfg_data  <= g;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // a close pair of vectors at a random scale, or now and then noise with random marks
  task automatic send_random_vector(output int unsigned count);
    int unsigned       len;
    int unsigned       span;
    int                delta;
    int                other;
    logic signed [15:0] a;
    logic              noisy;
    noisy = ($urandom_range(9) == 0);
    len   = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    span  = $urandom_range(15);
    for (int unsigned i = 0; i < len; i++) begin
      a = 16'($urandom);
      if (noisy) begin
        send_pair(int'(a), int'($signed(16'($urandom))),
                  (i == len - 1) ? 1'b1 : 1'($urandom));
      end else begin
        delta = int'($urandom_range(0, 2 << span)) - (1 << span);
        other = int'(a) - delta;
        if (other > 32767 || other < -32768) begin
          other = int'(a);
        end
        send_pair(int'(a), other, i == len - 1);
      end
    end
    count = len;
  endtask

  task automatic random_phase(input logic [rbf_pkg::GammaW-1:0] g);
    int unsigned sent;
    int unsigned n;
    write_gamma(g);
    sent = 0;
    while (sent < PhaseItems) begin
      send_random_vector(n);
      sent += n;
    end
    wait_idle();
  endtask

  task automatic random_sweep();
    random_phase(24'h010000);
    random_phase(24'($urandom_range(1, 1 << 18)));
    random_phase(24'hFF_FFFF);
    random_phase(24'($urandom_range(0, 24'hFF_FFFF)));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset gamma of one
    send_pair(0, 0, 1'b1);
    send_pair(32767, -32768, 1'b1);
    send_pair(-32768, 32767, 1'b1);
    send_pair(-32768, -32768, 1'b1);
    send_pair(32767, 32767, 1'b1);
    send_pair(4096, 0, 1'b1);
    send_pair(1, 0, 1'b1);
    send_pair(0, -1, 1'b1);
    send_pair(100, -100, 1'b0);
    send_pair(2048, -2048, 1'b0);
    send_pair(-300, 10, 1'b1);
    send_pair(5, 5, 1'b0);
    send_pair(-7, -7, 1'b1);
    send_pair(-21846, 21845, 1'b0);
    send_pair(21845, -21846, 1'b1);
    wait_idle();

    write_gamma(24'h00_0000);
    send_pair(32767, -32768, 1'b1);
    send_pair(1234, -999, 1'b1);
    wait_idle();

    write_gamma(24'hFF_FFFF);
    send_pair(1, 0, 1'b1);
    send_pair(0, 0, 1'b1);
    send_pair(64, 0, 1'b1);
    send_pair(-64, 0, 1'b1);
    wait_idle();

    random_sweep();

    send_idle_pct = 46;
    recv_idle_pct = 16;
    random_sweep();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_sweep();

    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #200_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
design/rbf_pkg.sv
design/rbf_front.sv
design/rbf_queue.sv
design/rbf_back.sv
design/rbf_kernel_evaluator.sv
tb/rbf_checker.sv
tb/tb_top.sv
